FILE: rtl/kill_switch_monitor_assert.svh
// ----------------------------------------------------------------------------
// kill switch monitor assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef KILL_SWITCH_MONITOR_ASSERT_SVH
`define KILL_SWITCH_MONITOR_ASSERT_SVH

// same-cycle implication
`define KSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ksm_pkg.sv
// ----------------------------------------------------------------------------
// kill switch monitor package
// shared constants and types for the kill switch monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ksm_pkg;

  localparam int NUM_SWITCHES_DEF = 8;
  localparam int SWITCH_IDX_W     = 3;
  localparam int ELAPSED_W        = 16;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 16;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;
  localparam logic [ELAPSED_W-1:0] TIMEOUT_RESET = 16'd1000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = 1'd1;

  // request function codes
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef struct packed {
    logic                    update;
    logic                    tick;
    logic [SWITCH_IDX_W-1:0] switch_index;
    logic                    assert_kill;
    logic                    needs_refresh;
  } bank_cmd_t;

  typedef struct packed {
    logic index_valid;
    logic kill_after_tick;
  } bank_status_t;

endpackage

FILE: rtl/ksm_req_if.sv
// ----------------------------------------------------------------------------
// kill switch monitor request channel
// valid/ready channel carrying one update or tick request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ksm_req_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [ksm_pkg::SWITCH_IDX_W-1:0] switch_index;
  logic                              assert_kill;
  logic                              needs_refresh;

  modport source (output valid, func, switch_index, assert_kill, needs_refresh,
                  input ready);
  modport sink (input valid, func, switch_index, assert_kill, needs_refresh,
                output ready);
endinterface

FILE: rtl/ksm_rsp_if.sv
// ----------------------------------------------------------------------------
// kill switch monitor response channel
// valid/ready channel carrying the kill state and event pulses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ksm_rsp_if;
  logic valid;
  logic ready;
  logic kill_asserted;
  logic kill_event;
  logic enable_event;

  modport source (output valid, kill_asserted, kill_event, enable_event,
                  input ready);
  modport sink (input valid, kill_asserted, kill_event, enable_event,
                output ready);
endinterface

FILE: rtl/ksm_switch_bank.sv
// ----------------------------------------------------------------------------
// kill switch bank
// per-switch flags and elapsed tick counters with kill evaluation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ksm_switch_bank #(
  parameter int NUM_SWITCHES = ksm_pkg::NUM_SWITCHES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ksm_pkg::bank_cmd_t               cmd,
  input  logic [ksm_pkg::ELAPSED_W-1:0]    timeout_ticks,
  output ksm_pkg::bank_status_t            status
);

  logic [NUM_SWITCHES-1:0] enabled;
  logic [NUM_SWITCHES-1:0] asserting;
  logic [NUM_SWITCHES-1:0] needs_refresh;
  logic [NUM_SWITCHES-1:0] sel;
  logic [NUM_SWITCHES-1:0] sw_kill;
  logic [ksm_pkg::ELAPSED_W-1:0] elapsed      [NUM_SWITCHES];
  logic [ksm_pkg::ELAPSED_W-1:0] elapsed_next [NUM_SWITCHES];

  for (genvar n = 0; n < NUM_SWITCHES; n++) begin : g_sw
    assign sel[n] = cmd.update && (32'(cmd.switch_index) == n);

    // saturating increment
    assign elapsed_next[n] = (elapsed[n] == ksm_pkg::ELAPSED_MAX) ? elapsed[n] :
                             elapsed[n] + 1'b1;

    assign sw_kill[n] = enabled[n] &&
                        (asserting[n] || (needs_refresh[n] && (elapsed_next[n] > timeout_ticks)));

    always_ff @(posedge clk) begin
      if (rst) begin
        enabled[n]       <= 1'b0;
        asserting[n]     <= 1'b0;
        needs_refresh[n] <= 1'b0;
        elapsed[n]       <= '0;
      end else if (sel[n]) begin
        enabled[n]       <= 1'b1;
        asserting[n]     <= cmd.assert_kill;
        needs_refresh[n] <= cmd.needs_refresh;
        elapsed[n]       <= '0;
      end else if (cmd.tick) begin
        elapsed[n]       <= elapsed_next[n];
      end
    end
  end

  assign status.index_valid     = 32'(cmd.switch_index) < NUM_SWITCHES;
  assign status.kill_after_tick = (|sw_kill) || !(|enabled);

endmodule

FILE: rtl/kill_switch_monitor.sv
// ----------------------------------------------------------------------------
// kill switch monitor
// combines kill switch sources into one kill state with event pulses
//
// channel  dir  content
// req      in   func, switch_index, assert_kill, needs_refresh
// rsp      out  kill_asserted, kill_event, enable_event
//
// one request per cycle while responses are taken; the response is registered and valid in the cycle after accept
// req ready is high whenever the response register is empty or being taken
// a stalled response holds the next request back, never drops it
// synchronous reset clears the switch table and asserts kill
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kill_switch_monitor #(
  parameter int NUM_SWITCHES = ksm_pkg::NUM_SWITCHES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  ksm_req_if.sink                            req,
  ksm_rsp_if.source                          rsp,
  input  logic                               cfg_we,
  input  logic [ksm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ksm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [ksm_pkg::ELAPSED_W-1:0] timeout_ticks;
  logic                          monitor_active;
  logic                          kill_state;
  logic                          kill_state_next;
  logic                          kill_ev_next;
  logic                          enable_ev_next;
  logic                          accept;
  logic                          rsp_valid;
  logic                          kill_asserted;
  logic                          kill_event;
  logic                          enable_event;
  ksm_pkg::bank_cmd_t            cmd;
  ksm_pkg::bank_status_t         status;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign cmd.update        = accept && (req.func == ksm_pkg::FUNC_UPDATE);
  assign cmd.tick          = accept && (req.func == ksm_pkg::FUNC_TICK);
  assign cmd.switch_index  = req.switch_index;
  assign cmd.assert_kill   = req.assert_kill;
  assign cmd.needs_refresh = req.needs_refresh;

  ksm_switch_bank #(
    .NUM_SWITCHES(NUM_SWITCHES)
  ) u_bank (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .timeout_ticks(timeout_ticks),
    .status       (status)
  );

  always_comb begin
    kill_state_next = kill_state;
    kill_ev_next    = 1'b0;
    enable_ev_next  = 1'b0;
    if (cmd.update && status.index_valid && monitor_active && req.assert_kill) begin
      kill_state_next = 1'b1;
      kill_ev_next    = 1'b1;
    end else if (cmd.tick && monitor_active &&
                 (status.kill_after_tick != kill_state)) begin
      kill_state_next = status.kill_after_tick;
      kill_ev_next    = status.kill_after_tick;
      enable_ev_next  = !status.kill_after_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks  <= ksm_pkg::TIMEOUT_RESET;
      monitor_active <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ksm_pkg::REG_TIMEOUT: timeout_ticks  <= cfg_data[ksm_pkg::ELAPSED_W-1:0];
        ksm_pkg::REG_ACTIVE:  monitor_active <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kill_state <= 1'b1;
      rsp_valid  <= 1'b0;
    end else begin
      if (accept) begin
        kill_state <= kill_state_next;
        rsp_valid  <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kill_asserted <= kill_state_next;
      kill_event    <= kill_ev_next;
      enable_event  <= enable_ev_next;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.kill_asserted = kill_asserted;
  assign rsp.kill_event    = kill_event;
  assign rsp.enable_event  = enable_event;

endmodule

FILE: rtl/ksm_checker.sv
// ----------------------------------------------------------------------------
// kill switch monitor checker
// port-level checks on responses and flow control
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "kill_switch_monitor_assert.svh"

module ksm_checker (
  input logic clk,
  input logic rst,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic kill_asserted,
  input logic kill_event,
  input logic enable_event
);

  `KSM_ASSERT_NOW(a_events_exclusive, clk, rst, rsp_valid, !(kill_event && enable_event), "kill and enable event together")
  `KSM_ASSERT_NOW(a_kill_event_state, clk, rst, rsp_valid && kill_event, kill_asserted, "kill event without kill")
  `KSM_ASSERT_NOW(a_enable_event_state, clk, rst, rsp_valid && enable_event, !kill_asserted, "enable event while killed")
  `KSM_ASSERT_NOW(a_ready_when_empty, clk, rst, !rsp_valid || rsp_ready, req_ready, "request stalled with free response slot")
  `KSM_ASSERT_NEXT(a_rsp_held, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "stalled response dropped")

endmodule

bind kill_switch_monitor ksm_checker u_ksm_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .kill_asserted(rsp.kill_asserted),
  .kill_event   (rsp.kill_event),
  .enable_event (rsp.enable_event)
);
